FILE: rtl/core/tsm_pkg.sv
// Shared types and constants of the thread and semaphore manager.
`timescale 1ns / 1ps
`default_nettype none
package tsm_pkg;

    localparam logic [3:0] OP_SPAWN      = 4'd0;
    localparam logic [3:0] OP_TICK       = 4'd1;
    localparam logic [3:0] OP_SEMCREATE  = 4'd2;
    localparam logic [3:0] OP_SEMSET     = 4'd3;
    localparam logic [3:0] OP_SEMUP      = 4'd4;
    localparam logic [3:0] OP_SEMDOWN    = 4'd5;
    localparam logic [3:0] OP_SEMDESTROY = 4'd6;
    localparam logic [3:0] OP_SENDSIG    = 4'd7;
    localparam logic [3:0] OP_WAITSIG    = 4'd8;
    localparam logic [3:0] OP_STOPRES    = 4'd9;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_ERR   = 2'd1;
    localparam logic [1:0] STAT_FATAL = 2'd2;

    localparam logic [14:0] PID_MAX = 15'h7FFF;

    typedef enum logic [2:0] {
        TS_FREE    = 3'd0,
        TS_READY   = 3'd1,
        TS_RUNNING = 3'd2,
        TS_WAITSEM = 3'd3,
        TS_WAITSIG = 3'd4,
        TS_STOPPED = 3'd5
    } t_tstate;

    typedef enum logic [5:0] {
        C_NONE, C_LATCH, C_TICK1, C_TICK2, C_SCAN_CLR,
        C_TSCAN_PID, C_TSCAN_TGT, C_SSCAN_FREE, C_SSCAN_ID, C_SSCAN_CTR,
        C_PID_STEP, C_SEMC_STEP, C_SPAWN1, C_APP0, C_APP1, C_APP2,
        C_SCREATE, C_SSET, C_SDEST, C_SUP1, C_SUP2, C_SDOWN_OK, C_FATAL,
        C_DOWN1, C_WALK, C_RM_CUR, C_RM_A, C_DOWN2, C_DOWN3,
        C_SIG1, C_SIG2, C_WS_OK, C_WS1, C_WS2, C_STOP, C_PUBLISH
    } t_cmd;

    typedef struct packed {
        logic [3:0] op;
        logic       flag;
        logic       hit;
        logic       t_last;
        logic       s_last;
        logic       free_nil;
        logic       pend_set;
        logic       wh_nil;
        logic       cnt_pos;
        logic       alone;
        logic       q_nil;
        logic       have;
        logic       wake;
        logic       t_ready;
        logic       t_stopped;
    } t_dp_status;

endpackage
`default_nettype wire

FILE: rtl/core/tsm_dpath.sv
// Datapath of the thread and semaphore manager: tables, links and scan registers.
`timescale 1ns / 1ps
`default_nettype none
module tsm_dpath
    import tsm_pkg::*;
#(
    parameter int THREAD_SLOTS = 16,
    parameter int SEM_SLOTS    = 16,
    parameter int SIGNAL_BITS  = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire t_cmd                            i_cmd,
    input  wire logic [3:0]                      i_opcode,
    input  wire logic                            i_resume_flag,
    input  wire logic [14:0]                     i_sem_ident_in,
    input  wire logic signed [15:0]              i_count_value,
    input  wire logic [14:0]                     i_target_pid,
    input  wire logic [15:0]                     i_signal_mask,
    output t_dp_status                           o_st,
    output logic [1:0]                           o_status_code,
    output logic [14:0]                          o_return_value,
    output logic [$clog2(THREAD_SLOTS)-1:0]      o_running_slot,
    output logic [14:0]                          o_running_pid,
    output logic                                 o_caller_blocked
);

    localparam int TW  = $clog2(THREAD_SLOTS);
    localparam int LW  = $clog2(THREAD_SLOTS + 1);
    localparam int SIW = (SEM_SLOTS > 1) ? $clog2(SEM_SLOTS) : 1;
    localparam int MX  = (THREAD_SLOTS > SEM_SLOTS) ? THREAD_SLOTS : SEM_SLOTS;
    localparam int IW  = $clog2(MX);
    localparam int SW  = (SIGNAL_BITS < 16) ? SIGNAL_BITS : 16;
    localparam logic [LW-1:0] NIL = LW'(THREAD_SLOTS);

    logic [3:0]         r_op;
    logic               r_flag;
    logic [14:0]        r_sid;
    logic signed [15:0] r_cval;
    logic [14:0]        r_tpid;
    logic [SW-1:0]      r_mask;

    logic [TW-1:0]  r_cur;
    logic [LW-1:0]  r_pend, r_free, r_a, r_b;
    logic [14:0]    r_pidc, r_pid, r_semc, r_rv;
    logic [IW-1:0]  r_idx;
    logic           r_hit, r_blk;
    logic [SIW-1:0] r_s, r_f;
    logic [1:0]     r_status;

    logic [14:0]    r_ident [THREAD_SLOTS];
    t_tstate        r_state [THREAD_SLOTS];
    logic [LW-1:0]  r_lf    [THREAD_SLOTS];
    logic [LW-1:0]  r_lb    [THREAD_SLOTS];
    logic [SW-1:0]  r_rs    [THREAD_SLOTS];
    logic [SW-1:0]  r_as    [THREAD_SLOTS];
    logic           r_inuse [SEM_SLOTS];
    logic [14:0]    r_sid_t [SEM_SLOTS];
    logic signed [15:0] r_cnt [SEM_SLOTS];
    logic [LW-1:0]  r_wh    [SEM_SLOTS];

    logic [TW-1:0]  a_i, b_i, idx_t, free_i, rm_n, pr_i, nx_i;
    logic [SIW-1:0] idx_s;
    logic [14:0]    tkey, skey, n_pidc, n_pid;
    logic           t_match, s_match, tk_go;
    logic [LW-1:0]  tk_nx, rm_pr, rm_nx;
    logic signed [15:0] cnt_up, cnt_dn;

    assign a_i    = r_a[TW-1:0];
    assign b_i    = r_b[TW-1:0];
    assign idx_t  = r_idx[TW-1:0];
    assign idx_s  = r_idx[SIW-1:0];
    assign free_i = r_free[TW-1:0];

    assign tkey    = (i_cmd == C_TSCAN_PID) ? r_pid : r_tpid;
    assign skey    = (i_cmd == C_SSCAN_ID) ? r_sid : r_semc;
    assign t_match = (r_state[idx_t] != TS_FREE) && (r_ident[idx_t] == tkey);
    assign s_match = r_inuse[idx_s] && (r_sid_t[idx_s] == skey);
    assign n_pidc  = (r_pidc == PID_MAX) ? 15'd1 : r_pidc + 15'd1;
    assign n_pid   = (r_pid == PID_MAX) ? 15'd1 : r_pid + 15'd1;

    assign tk_nx = (r_pend == NIL) ? r_lf[r_cur] : r_pend;
    assign tk_go = (tk_nx != LW'(r_cur)) && (tk_nx < NIL);

    assign rm_n  = (i_cmd == C_RM_CUR) ? r_cur : a_i;
    assign rm_pr = r_lb[rm_n];
    assign rm_nx = r_lf[rm_n];
    assign pr_i  = rm_pr[TW-1:0];
    assign nx_i  = rm_nx[TW-1:0];

    assign cnt_up = (r_cnt[r_s] == 16'sh7FFF) ? r_cnt[r_s] : r_cnt[r_s] + 16'sd1;
    assign cnt_dn = (r_cnt[r_s] == -16'sh8000) ? r_cnt[r_s] : r_cnt[r_s] - 16'sd1;

    always_comb begin
        o_st.op        = r_op;
        o_st.flag      = r_flag;
        o_st.hit       = r_hit;
        o_st.t_last    = (r_idx == IW'(THREAD_SLOTS - 1));
        o_st.s_last    = (r_idx == IW'(SEM_SLOTS - 1));
        o_st.free_nil  = (r_free == NIL);
        o_st.pend_set  = (r_pend != NIL);
        o_st.wh_nil    = (r_wh[r_s] == NIL);
        o_st.cnt_pos   = (r_cnt[r_s] > 16'sd0);
        o_st.alone     = (r_lf[r_cur] == LW'(r_cur));
        o_st.q_nil     = (r_b == NIL);
        o_st.have      = ((r_rs[r_cur] & r_mask) == r_mask);
        o_st.wake      = (r_state[a_i] == TS_WAITSIG) &&
                         ((r_rs[a_i] & r_as[a_i]) == r_as[a_i]);
        o_st.t_ready   = (r_state[a_i] == TS_READY);
        o_st.t_stopped = (r_state[a_i] == TS_STOPPED);
    end

    // Semaphore payload fields are only read after a create has written them.
    always_ff @(posedge i_clk) begin
        case (i_cmd)
            C_SCREATE: begin
                r_sid_t[r_f] <= r_semc;
                r_cnt[r_f]   <= r_cval;
                r_wh[r_f]    <= NIL;
            end
            C_SSET: begin
                if (r_wh[r_s] == NIL) r_cnt[r_s] <= r_cval;
            end
            C_SUP1:                r_cnt[r_s] <= cnt_up;
            C_SDOWN_OK, C_DOWN1:   r_cnt[r_s] <= cnt_dn;
            C_SUP2:                r_wh[r_s]  <= r_lf[a_i];
            C_DOWN2: begin
                if (r_a == NIL) r_wh[r_s] <= LW'(r_cur);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < THREAD_SLOTS; i++) begin
                r_ident[i] <= '0;
                r_state[i] <= (i == 0) ? TS_RUNNING : TS_FREE;
                r_lf[i]    <= (i == 0) ? '0 :
                              ((i < THREAD_SLOTS - 1) ? LW'(i + 1) : NIL);
                r_lb[i]    <= (i == 0) ? '0 : NIL;
                r_rs[i]    <= '0;
                r_as[i]    <= '0;
            end
            for (int j = 0; j < SEM_SLOTS; j++) r_inuse[j] <= 1'b0;
            r_cur    <= '0;
            r_pend   <= NIL;
            r_free   <= LW'(1);
            r_pidc   <= 15'd1;
            r_semc   <= '0;
            r_idx    <= '0;
            r_hit    <= 1'b0;
            r_status <= STAT_ERR;
            r_rv     <= '0;
            r_blk    <= 1'b0;
        end else begin
            case (i_cmd)
                C_LATCH: begin
                    r_op     <= i_opcode;
                    r_flag   <= i_resume_flag;
                    r_sid    <= i_sem_ident_in;
                    r_cval   <= i_count_value;
                    r_tpid   <= i_target_pid;
                    r_mask   <= i_signal_mask[SW-1:0];
                    r_status <= STAT_ERR;
                    r_rv     <= '0;
                    r_blk    <= 1'b0;
                end
                C_TICK1: begin
                    r_b      <= tk_nx;
                    r_hit    <= tk_go;
                    r_pend   <= NIL;
                    r_status <= STAT_OK;
                    if (tk_go && r_state[r_cur] == TS_RUNNING) r_state[r_cur] <= TS_READY;
                end
                C_TICK2: begin
                    if (r_hit) begin
                        r_cur        <= b_i;
                        r_state[b_i] <= TS_RUNNING;
                    end
                end
                C_SCAN_CLR: begin
                    r_idx <= '0;
                    r_hit <= 1'b0;
                    r_pid <= r_pidc;
                end
                C_TSCAN_PID, C_TSCAN_TGT: begin
                    if (t_match && !r_hit) begin
                        r_hit <= 1'b1;
                        r_a   <= LW'(idx_t);
                    end
                    r_idx <= r_idx + 1'b1;
                end
                C_SSCAN_FREE: begin
                    if (!r_inuse[idx_s] && !r_hit) begin
                        r_hit <= 1'b1;
                        r_f   <= idx_s;
                    end
                    r_idx <= r_idx + 1'b1;
                end
                C_SSCAN_ID, C_SSCAN_CTR: begin
                    if (s_match && !r_hit) begin
                        r_hit <= 1'b1;
                        r_s   <= idx_s;
                    end
                    r_idx <= r_idx + 1'b1;
                end
                C_PID_STEP: begin
                    r_pidc <= n_pidc;
                    if (r_hit) r_pid <= n_pid;
                    r_idx <= '0;
                    r_hit <= 1'b0;
                end
                C_SEMC_STEP: begin
                    if (r_hit) r_semc <= r_semc + 15'd1;
                    r_idx <= '0;
                    r_hit <= 1'b0;
                end
                C_SPAWN1: begin
                    r_a             <= r_free;
                    r_free          <= r_lf[free_i];
                    r_ident[free_i] <= r_pid;
                    r_rs[free_i]    <= '0;
                    r_as[free_i]    <= '0;
                    r_rv            <= r_pid;
                    r_status        <= STAT_OK;
                end
                C_APP0: r_b <= r_lb[r_cur];
                C_APP1: begin
                    r_lb[a_i]    <= r_b;
                    r_lf[a_i]    <= LW'(r_cur);
                    r_state[a_i] <= TS_READY;
                    r_status     <= STAT_OK;
                end
                C_APP2: begin
                    r_lf[b_i]   <= r_a;
                    r_lb[r_cur] <= r_a;
                end
                C_SCREATE: begin
                    r_inuse[r_f] <= 1'b1;
                    r_rv         <= r_semc;
                    r_semc       <= r_semc + 15'd1;
                    r_status     <= STAT_OK;
                end
                C_SSET: begin
                    if (r_wh[r_s] == NIL) r_status <= STAT_OK;
                end
                C_SDEST: begin
                    if (r_wh[r_s] == NIL) begin
                        r_inuse[r_s] <= 1'b0;
                        r_status     <= STAT_OK;
                    end
                end
                C_SUP1: begin
                    r_a      <= r_wh[r_s];
                    r_status <= STAT_OK;
                end
                C_SDOWN_OK: r_status <= STAT_OK;
                C_FATAL:    r_status <= STAT_FATAL;
                C_DOWN1: begin
                    r_b <= r_wh[r_s];
                    r_a <= NIL;
                end
                C_WALK: begin
                    r_a <= r_b;
                    r_b <= r_lf[b_i];
                end
                C_RM_CUR, C_RM_A: begin
                    r_lf[pr_i] <= rm_nx;
                    r_lb[nx_i] <= rm_pr;
                end
                C_DOWN2: begin
                    if (r_a != NIL) r_lf[a_i] <= LW'(r_cur);
                    r_state[r_cur] <= TS_WAITSEM;
                    r_pend         <= r_lf[r_cur];
                    r_blk          <= 1'b1;
                    r_status       <= STAT_OK;
                end
                C_DOWN3: r_lf[r_cur] <= NIL;
                C_SIG1: begin
                    r_rs[a_i] <= r_rs[a_i] | r_mask;
                    r_status  <= STAT_OK;
                end
                C_SIG2: begin
                    r_rs[a_i] <= r_rs[a_i] ^ r_as[a_i];
                    r_as[a_i] <= '0;
                end
                C_WS_OK: begin
                    r_rs[r_cur] <= r_rs[r_cur] ^ r_mask;
                    r_as[r_cur] <= '0;
                    r_status    <= STAT_OK;
                end
                C_WS1: r_as[r_cur] <= r_mask;
                C_WS2: begin
                    r_state[r_cur] <= TS_WAITSIG;
                    r_pend         <= r_lf[r_cur];
                    r_blk          <= 1'b1;
                    r_status       <= STAT_OK;
                end
                C_STOP: begin
                    r_state[a_i] <= TS_STOPPED;
                    r_status     <= STAT_OK;
                end
                default: ;
            endcase
        end
    end

    // Result register; loaded only when the output side can take it.
    always_ff @(posedge i_clk) begin
        if (i_cmd == C_PUBLISH) begin
            o_status_code    <= r_status;
            o_return_value   <= r_rv;
            o_running_slot   <= r_cur;
            o_running_pid    <= r_ident[r_cur];
            o_caller_blocked <= r_blk;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/tsm_ctrl.sv
// Controller state machine of the thread and semaphore manager.
`timescale 1ns / 1ps
`default_nettype none
module tsm_ctrl
    import tsm_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    output logic            o_valid,
    input  wire logic       i_ready,
    input  wire t_dp_status i_st,
    output t_cmd            o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE, S_DEC, S_TICK1, S_TICK2, S_PSCAN, S_PSTEP, S_SPAWN1,
        S_APP0, S_APP1, S_APP2, S_SFSCAN, S_SFCHK, S_SCSCAN, S_SCCHK,
        S_SCREATE, S_SISCAN, S_SICHK, S_SSET, S_SDEST, S_SUP1, S_SUP2,
        S_SDOWN_OK, S_FATAL, S_DOWN1, S_WALK, S_RMCUR, S_DOWN2, S_DOWN3,
        S_TTSCAN, S_TTCHK, S_SIG1, S_SIGCHK, S_SIG2, S_RMA, S_STOP,
        S_WS1, S_WS2, S_WS_OK, S_FIN
    } t_state;

    t_state r_state, n_state;
    logic   r_ovalid, n_ovalid;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_ovalid;

    always_comb begin
        n_state  = r_state;
        o_cmd    = C_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd   = C_LATCH;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                o_cmd = C_SCAN_CLR;
                if (i_st.op == OP_TICK) n_state = S_TICK1;
                else if (i_st.pend_set) n_state = S_FIN;
                else begin
                    case (i_st.op)
                        OP_SPAWN:     n_state = i_st.free_nil ? S_FIN : S_PSCAN;
                        OP_SEMCREATE: n_state = S_SFSCAN;
                        OP_SEMSET, OP_SEMUP, OP_SEMDOWN, OP_SEMDESTROY:
                                      n_state = S_SISCAN;
                        OP_SENDSIG, OP_STOPRES: n_state = S_TTSCAN;
                        OP_WAITSIG: begin
                            if (i_st.have)       n_state = S_WS_OK;
                            else if (i_st.alone) n_state = S_FATAL;
                            else                 n_state = S_WS1;
                        end
                        default:      n_state = S_FIN;
                    endcase
                end
            end
            S_TICK1:  begin o_cmd = C_TICK1; n_state = S_TICK2; end
            S_TICK2:  begin o_cmd = C_TICK2; n_state = S_FIN; end
            S_PSCAN:  begin
                o_cmd = C_TSCAN_PID;
                if (i_st.t_last) n_state = S_PSTEP;
            end
            S_PSTEP:  begin
                o_cmd   = C_PID_STEP;
                n_state = i_st.hit ? S_PSCAN : S_SPAWN1;
            end
            S_SPAWN1: begin o_cmd = C_SPAWN1; n_state = S_APP0; end
            S_APP0:   begin o_cmd = C_APP0; n_state = S_APP1; end
            S_APP1:   begin o_cmd = C_APP1; n_state = S_APP2; end
            S_APP2:   begin o_cmd = C_APP2; n_state = S_FIN; end
            S_SFSCAN: begin
                o_cmd = C_SSCAN_FREE;
                if (i_st.s_last) n_state = S_SFCHK;
            end
            S_SFCHK:  begin
                o_cmd   = C_SCAN_CLR;
                n_state = i_st.hit ? S_SCSCAN : S_FIN;
            end
            S_SCSCAN: begin
                o_cmd = C_SSCAN_CTR;
                if (i_st.s_last) n_state = S_SCCHK;
            end
            S_SCCHK:  begin
                o_cmd   = C_SEMC_STEP;
                n_state = i_st.hit ? S_SCSCAN : S_SCREATE;
            end
            S_SCREATE: begin o_cmd = C_SCREATE; n_state = S_FIN; end
            S_SISCAN: begin
                o_cmd = C_SSCAN_ID;
                if (i_st.s_last) n_state = S_SICHK;
            end
            S_SICHK:  begin
                if (!i_st.hit) n_state = S_FIN;
                else begin
                    case (i_st.op)
                        OP_SEMSET:     n_state = S_SSET;
                        OP_SEMDESTROY: n_state = S_SDEST;
                        OP_SEMUP:      n_state = S_SUP1;
                        default: begin
                            if (i_st.cnt_pos)    n_state = S_SDOWN_OK;
                            else if (i_st.alone) n_state = S_FATAL;
                            else                 n_state = S_DOWN1;
                        end
                    endcase
                end
            end
            S_SSET:   begin o_cmd = C_SSET; n_state = S_FIN; end
            S_SDEST:  begin o_cmd = C_SDEST; n_state = S_FIN; end
            S_SUP1:   begin
                o_cmd   = C_SUP1;
                n_state = i_st.wh_nil ? S_FIN : S_SUP2;
            end
            S_SUP2:   begin o_cmd = C_SUP2; n_state = S_APP0; end
            S_SDOWN_OK: begin o_cmd = C_SDOWN_OK; n_state = S_FIN; end
            S_FATAL:  begin o_cmd = C_FATAL; n_state = S_FIN; end
            S_DOWN1:  begin o_cmd = C_DOWN1; n_state = S_WALK; end
            S_WALK:   begin
                if (i_st.q_nil) n_state = S_RMCUR;
                else            o_cmd   = C_WALK;
            end
            S_RMCUR:  begin
                o_cmd   = C_RM_CUR;
                n_state = (i_st.op == OP_WAITSIG) ? S_WS2 : S_DOWN2;
            end
            S_DOWN2:  begin o_cmd = C_DOWN2; n_state = S_DOWN3; end
            S_DOWN3:  begin o_cmd = C_DOWN3; n_state = S_FIN; end
            S_TTSCAN: begin
                o_cmd = C_TSCAN_TGT;
                if (i_st.t_last) n_state = S_TTCHK;
            end
            S_TTCHK:  begin
                if (!i_st.hit)                            n_state = S_FIN;
                else if (i_st.op == OP_SENDSIG)           n_state = S_SIG1;
                else if (!i_st.flag && i_st.t_ready)      n_state = S_RMA;
                else if (i_st.flag && i_st.t_stopped)     n_state = S_APP0;
                else                                      n_state = S_FIN;
            end
            S_SIG1:   begin o_cmd = C_SIG1; n_state = S_SIGCHK; end
            S_SIGCHK: n_state = i_st.wake ? S_SIG2 : S_FIN;
            S_SIG2:   begin o_cmd = C_SIG2; n_state = S_APP0; end
            S_RMA:    begin o_cmd = C_RM_A; n_state = S_STOP; end
            S_STOP:   begin o_cmd = C_STOP; n_state = S_FIN; end
            S_WS1:    begin o_cmd = C_WS1; n_state = S_RMCUR; end
            S_WS2:    begin o_cmd = C_WS2; n_state = S_FIN; end
            S_WS_OK:  begin o_cmd = C_WS_OK; n_state = S_FIN; end
            S_FIN:    begin
                if (!r_ovalid || i_ready) begin
                    o_cmd   = C_PUBLISH;
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_ovalid = r_ovalid;
        if (r_ovalid && i_ready) n_ovalid = 1'b0;
        if (o_cmd == C_PUBLISH)  n_ovalid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/thread_semaphore_manager_unit.sv
// Top level of the thread and semaphore manager: controller plus datapath.
`timescale 1ns / 1ps
`default_nettype none
//
//  Channel   Direction  Handshake          Transfer carries
//  request   in         i_valid / o_ready  opcode, resume flag, semaphore id,
//                                          count, target pid, signal mask
//  result    out        o_valid / i_ready  status, return value, running slot,
//                                          running pid, caller blocked flag
//
//  One request is processed at a time. A tick steps through decode, two tick
//  states and publish before the next ready, and a call refused at decode goes
//  straight to publish; a table lookup walks one slot per cycle over all
//  THREAD_SLOTS or SEM_SLOTS slots, and a spawn repeats the pid scan
//  once per candidate pid that is already in use.
//  A semaphore down that blocks also walks the wait queue, one entry a cycle.
//  Reset is synchronous and active low and leaves slot 0 running alone.
//  A result waiting on a stalled output does not stop the next request from
//  being taken; only the publish of its result waits for the output register.
//
module thread_semaphore_manager_unit
    import tsm_pkg::*;
#(
    parameter int THREAD_SLOTS = 16,
    parameter int SEM_SLOTS    = 16,
    parameter int SIGNAL_BITS  = 16
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic [3:0]                  i_opcode,
    input  wire logic                        i_resume_flag,
    input  wire logic [14:0]                 i_sem_ident_in,
    input  wire logic signed [15:0]          i_count_value,
    input  wire logic [14:0]                 i_target_pid,
    input  wire logic [15:0]                 i_signal_mask,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic [1:0]                       o_status_code,
    output logic [14:0]                      o_return_value,
    output logic [$clog2(THREAD_SLOTS)-1:0]  o_running_slot,
    output logic [14:0]                      o_running_pid,
    output logic                             o_caller_blocked
);

    // The controller sequences one command per cycle; the datapath reports
    // back the flags that steer the sequence.
    t_cmd       cmd;
    t_dp_status st;

    tsm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_st    (st),
        .o_cmd   (cmd)
    );

    // The datapath holds the thread table, the ready ring links and the
    // semaphore table, and the result register that feeds the output ports.
    tsm_dpath #(
        .THREAD_SLOTS (THREAD_SLOTS),
        .SEM_SLOTS    (SEM_SLOTS),
        .SIGNAL_BITS  (SIGNAL_BITS)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_opcode         (i_opcode),
        .i_resume_flag    (i_resume_flag),
        .i_sem_ident_in   (i_sem_ident_in),
        .i_count_value    (i_count_value),
        .i_target_pid     (i_target_pid),
        .i_signal_mask    (i_signal_mask),
        .o_st             (st),
        .o_status_code    (o_status_code),
        .o_return_value   (o_return_value),
        .o_running_slot   (o_running_slot),
        .o_running_pid    (o_running_pid),
        .o_caller_blocked (o_caller_blocked)
    );

endmodule
`default_nettype wire
